// ===== rtl/core/lps_pkg.sv =====
package lps_pkg;

    localparam logic [2:0] NUM_PATTERNS = 3'd7;

    localparam logic [2:0] PAT_IDLE        = 3'd0;
    localparam logic [2:0] PAT_RUNNING     = 3'd1;
    localparam logic [2:0] PAT_PROGRAMMING = 3'd2;
    localparam logic [2:0] PAT_STEP_LOCKED = 3'd3;
    localparam logic [2:0] PAT_SAVE_OK     = 3'd4;
    localparam logic [2:0] PAT_INPUT_ERROR = 3'd5;
    localparam logic [2:0] PAT_ESTOP       = 3'd6;

    localparam logic CMD_SELECT  = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    // Remaining time reported for a segment index past the end of a pattern.
    localparam logic [10:0] OOR_REMAINING_MS = 11'd100;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } lps_state_t;

    typedef struct packed {
        logic        cmd;
        logic [3:0]  pattern_request;
        logic [15:0] step_ms;
    } lps_cmd_t;

    typedef struct packed {
        logic        led_level;
        logic [2:0]  active_pattern;
        logic [2:0]  base_pattern;
        logic [10:0] remaining_ms;
    } lps_res_t;

    function automatic logic [4:0] pat_count(input logic [2:0] p);
        case (p)
            PAT_IDLE:        pat_count = 5'd2;
            PAT_RUNNING:     pat_count = 5'd1;
            PAT_PROGRAMMING: pat_count = 5'd2;
            PAT_STEP_LOCKED: pat_count = 5'd4;
            PAT_SAVE_OK:     pat_count = 5'd1;
            PAT_INPUT_ERROR: pat_count = 5'd6;
            PAT_ESTOP:       pat_count = 5'd10;
            default:         pat_count = 5'd2;
        endcase
    endfunction

    function automatic logic pat_transient(input logic [2:0] p);
        case (p)
            PAT_STEP_LOCKED, PAT_SAVE_OK, PAT_INPUT_ERROR, PAT_ESTOP: pat_transient = 1'b1;
            default: pat_transient = 1'b0;
        endcase
    endfunction

    // Transient patterns that resume the base pattern when they end.
    function automatic logic pat_to_base(input logic [2:0] p);
        case (p)
            PAT_STEP_LOCKED, PAT_INPUT_ERROR: pat_to_base = 1'b1;
            default: pat_to_base = 1'b0;
        endcase
    endfunction

    // Fixed return pattern of the other transients.
    function automatic logic [2:0] pat_ret(input logic [2:0] p);
        case (p)
            default: pat_ret = PAT_IDLE;
        endcase
    endfunction

    function automatic logic [10:0] seg_dur(input logic [2:0] p, input logic [3:0] idx);
        case (p)
            PAT_RUNNING:     seg_dur = 11'd1000;
            PAT_PROGRAMMING: seg_dur = 11'd1000;
            PAT_STEP_LOCKED: seg_dur = 11'd80;
            PAT_SAVE_OK:     seg_dur = 11'd2000;
            PAT_INPUT_ERROR: seg_dur = 11'd60;
            PAT_ESTOP:       seg_dur = 11'd50;
            default:         seg_dur = (idx == 4'd0) ? 11'd100 : 11'd1900;
        endcase
    endfunction

    // Every pattern starts on and alternates on and off.
    function automatic logic seg_lvl(input logic [3:0] idx);
        seg_lvl = ~idx[0];
    endfunction

endpackage

// ===== rtl/core/lps_core.sv =====
module lps_core #(
    parameter int MAX_SEGMENTS = 12
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  lps_pkg::lps_cmd_t cmd_in,
    output logic             ready,
    output logic             res_valid,
    input  logic             res_take,
    output lps_pkg::lps_res_t res_out
);
    import lps_pkg::*;

    localparam logic [4:0] SEG_CAP = 5'(MAX_SEGMENTS);

    lps_state_t  state_reg, state_next;
    logic [2:0]  cur_reg, cur_next;
    logic [2:0]  base_reg, base_next;
    logic [3:0]  idx_reg, idx_next;
    logic [16:0] elap_reg, elap_next;

    logic [4:0]  pcount;
    logic [4:0]  count;
    logic        in_range;
    logic [10:0] dur;
    logic [17:0] diff;
    logic        fits;
    logic [4:0]  idx_inc;
    logic [2:0]  sel_pat;

    assign pcount   = pat_count(cur_reg);
    assign count    = (pcount > SEG_CAP) ? SEG_CAP : pcount;
    assign in_range = {1'b0, idx_reg} < count;
    assign dur      = seg_dur(cur_reg, idx_reg);
    // Shared subtractor: tests whether the segment has finished and yields the carry-over.
    assign diff     = {1'b0, elap_reg} - {7'd0, dur};
    assign fits     = in_range && !diff[17];
    assign idx_inc  = {1'b0, idx_reg} + 5'd1;
    assign sel_pat  = (cmd_in.pattern_request >= {1'b0, NUM_PATTERNS}) ? PAT_IDLE
                                                                       : cmd_in.pattern_request[2:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cur_reg   <= PAT_IDLE;
            base_reg  <= PAT_IDLE;
            idx_reg   <= 4'd0;
            elap_reg  <= 17'd0;
        end else begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            base_reg  <= base_next;
            idx_reg   <= idx_next;
            elap_reg  <= elap_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = (cmd_in.cmd == CMD_SELECT) ? ST_DONE : ST_WALK;
                end
            end
            ST_WALK: begin
                if (!fits) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (res_take) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cur_next  = cur_reg;
        base_next = base_reg;
        idx_next  = idx_reg;
        elap_next = elap_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    if (cmd_in.cmd == CMD_SELECT) begin
                        if (!pat_transient(sel_pat)) begin
                            base_next = sel_pat;
                        end
                        cur_next  = sel_pat;
                        idx_next  = 4'd0;
                        elap_next = 17'd0;
                    end else begin
                        elap_next = elap_reg + {1'b0, cmd_in.step_ms};
                    end
                end
            end
            ST_WALK: begin
                if (fits) begin
                    elap_next = diff[16:0];
                    if (idx_inc >= count) begin
                        idx_next = 4'd0;
                        if (pat_transient(cur_reg)) begin
                            // Leftover time is dropped when a transient ends.
                            elap_next = 17'd0;
                            if (pat_to_base(cur_reg)) begin
                                cur_next = base_reg;
                            end else begin
                                cur_next  = pat_ret(cur_reg);
                                base_next = pat_ret(cur_reg);
                            end
                        end
                    end else begin
                        idx_next = idx_inc[3:0];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        ready                  = (state_reg == ST_IDLE);
        res_valid              = (state_reg == ST_DONE);
        res_out.active_pattern = cur_reg;
        res_out.base_pattern   = base_reg;
        if (in_range) begin
            res_out.led_level    = seg_lvl(idx_reg);
            res_out.remaining_ms = diff[17] ? (dur - elap_reg[10:0]) : 11'd0;
        end else begin
            res_out.led_level    = 1'b0;
            res_out.remaining_ms = OOR_REMAINING_MS;
        end
    end

endmodule

// ===== rtl/core/led_pattern_sequencer.sv =====
// Status LED blink pattern sequencer.
// Input channel (s_): one command per transfer. s_tuser selects the command:
// select a pattern (pattern_request, codes above 6 give idle) or advance time
// by step_ms. Result channel (m_): one result per command with the LED
// level, the active and base patterns and the time left in the current segment.
// A select command goes straight to its result; the result is then loaded into
// the output register, which raises m_tvalid. An advance command walks one
// finished segment per cycle before its result is loaded the same way;
// a full 65535 ms step on a looping pattern walks up to about 70 segments.
// s_tready is low while a command is in work and one shared duration
// subtractor sets that walk rate.
// The result sits in an output register, so the next command is taken while
// an earlier result waits. If the receiver stalls with a result pending, the
// following result waits in the core and s_tready stays low until it drains.
// Reset (aresetn low, synchronous) plays idle at its first segment with idle
// as base pattern and empties the output register.
module led_pattern_sequencer #(
    parameter int MAX_SEGMENTS = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // pattern_request[3:0], step_ms[19:4], zero fill
    input  logic [0:0]  s_tuser,   // cmd[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // led_level[0], active_pattern[3:1], base_pattern[6:4],
                                   // remaining_ms[17:7], zero fill
);
    import lps_pkg::*;

    lps_cmd_t cmd_in;
    lps_res_t core_res;
    logic     core_ready;
    logic     core_valid;
    logic     load;
    logic     start;

    logic     m_tvalid_reg, m_tvalid_next;
    lps_res_t res_reg, res_next;

    assign cmd_in.cmd             = s_tuser[0];
    assign cmd_in.pattern_request = s_tdata[3:0];
    assign cmd_in.step_ms         = s_tdata[19:4];

    assign s_tready = core_ready;
    assign start    = s_tvalid && core_ready;
    assign load     = core_valid && (!m_tvalid_reg || m_tready);

    lps_core #(
        .MAX_SEGMENTS(MAX_SEGMENTS)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .cmd_in   (cmd_in),
        .ready    (core_ready),
        .res_valid(core_valid),
        .res_take (load),
        .res_out  (core_res)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        res_next      = res_reg;
        if (load) begin
            m_tvalid_next = 1'b1;
            res_next      = core_res;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, res_reg.remaining_ms, res_reg.base_pattern,
                       res_reg.active_pattern, res_reg.led_level};

endmodule

// ===== rtl/core/lps_checker.sv =====
module lps_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // A held result keeps its value until the transfer completes.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Every command makes the block busy, so s_tready drops after each transfer.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command taken on consecutive cycles");

    // The base pattern is always a looping pattern.
    a_base: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[6:4] <= 3'd2)
        else $error("base pattern is transient");

    a_active: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[3:1] != 3'd7 && m_tdata[17:7] <= 11'd2000)
        else $error("active pattern or remaining time out of range");

endmodule

bind led_pattern_sequencer lps_checker u_lps_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);
